// ===== hdl/ihfd_pkg.sv =====
// Package for the hex-float to IEEE double converter.
// Status codes, constants and the leading-one helper. No dependencies.
package ihfd_pkg;

  localparam logic [63:0] NA_PATTERN = 64'h7FF0_0000_0000_07A2;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_BADLEN  = 2'd2
  } status_t;

  // Position of the top set bit of a nonzero 56-bit fraction
  function automatic logic [5:0] top_bit(input logic [55:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

// ===== hdl/ibm_hex_float_to_ieee_double_top.sv =====
// Top level of the hex-float to IEEE double converter.
// Depends on ihfd_pkg and ihfd_convert.
//
// Usage:
//   Input channel (valid/ready) carries raw_bytes and field_length; output
//   channel (out_valid/out_ready) carries double_bits and status.
//   Each input transfer is registered; conversion logic sits between the
//   input register and the result register.
//   A result is valid once the result register has taken it from the input
//   register; a stalled receiver can hold it back there.
//   Throughput: one item per cycle while out_ready is high; the rate is set by the single
//   normalize/round pass between the two registers.
//   in_ready is high whenever the input stage is empty or will move on, so
//   a new field is taken while an earlier result still waits.
//   When the receiver stalls, results hold in the output register and the
//   input register fills, after which in_ready drops.
//   Reset (rst, synchronous) empties both stages; no result is pending.
//   Status: 0 converted, 1 missing value, 2 bad field length.
//
module ibm_hex_float_to_ieee_double_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] raw_bytes,
  input  logic [3:0]  field_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] double_bits,
  output logic [1:0]  status
);

  logic        s1_valid;
  logic [63:0] s1_raw;
  logic [3:0]  s1_len;
  logic [63:0] conv_bits;
  ihfd_pkg::status_t conv_status;
  logic        s2_load;

  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_raw <= raw_bytes;
      s1_len <= field_length;
    end
  end

  ihfd_convert u_convert (
    .raw_bytes   (s1_raw),
    .field_length(s1_len),
    .double_bits (conv_bits),
    .status      (conv_status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_load) begin
      double_bits <= conv_bits;
      status      <= conv_status;
    end
  end

endmodule

// ===== hdl/ihfd_convert.sv =====
// Combinational conversion of one field: length check, NA detect, normalize, round.
// Depends on ihfd_pkg.
module ihfd_convert (
  input  logic [63:0]      raw_bytes,
  input  logic [3:0]       field_length,
  output logic [63:0]      double_bits,
  output ihfd_pkg::status_t status
);

  logic [63:0] mask;
  logic [63:0] raw;
  logic [55:0] frac;
  logic [6:0]  ex;
  logic [5:0]  p;
  logic [10:0] biased;
  logic [53:0] mant;
  logic [53:0] shr;
  logic [2:0]  rem;
  logic [2:0]  half;
  logic        rnd;
  logic [1:0]  s;
  logic        len_ok;

  always_comb begin
    len_ok = (field_length >= 4'd2) && (field_length <= 4'd8);
    // keep the leading field_length bytes
    mask = ~64'd0 << (7'd64 - {field_length[3:0], 3'd0});
    raw  = raw_bytes & (len_ok ? mask : 64'd0);
    ex   = raw[62:56];
    frac = raw[55:0];
    p    = ihfd_pkg::top_bit(frac);
    biased = 11'(p) + {2'd0, ex, 2'd0} + 11'd711;
    s    = 2'd0;
    rem  = 3'd0;
    half = 3'd0;
    shr  = 54'd0;
    rnd  = 1'b0;
    if (p <= 6'd52) begin
      mant = 54'(frac << (6'd52 - p));
    end else begin
      s    = 2'(p - 6'd52);
      shr  = 54'(frac >> s);
      rem  = frac[2:0] & ~(3'b111 << s);
      half = 3'd1 << (s - 2'd1);
      rnd  = (rem > half) || ((rem == half) && shr[0]);
      mant = shr + 54'(rnd);
      if (mant[53]) begin
        mant   = mant >> 1;
        biased = biased + 11'd1;
      end
    end

    if (!len_ok) begin
      double_bits = 64'd0;
      status      = ihfd_pkg::STATUS_BADLEN;
    end else if (raw[55:48] == 8'd0 && raw[63:56] != 8'd0) begin
      double_bits = ihfd_pkg::NA_PATTERN;
      status      = ihfd_pkg::STATUS_MISSING;
    end else if (frac == 56'd0) begin
      double_bits = 64'd0;
      status      = ihfd_pkg::STATUS_OK;
    end else begin
      double_bits = {raw[63], biased, mant[51:0]};
      status      = ihfd_pkg::STATUS_OK;
    end
  end

endmodule

// ===== hdl/ihfd_checker.sv =====
// Port-level checker for the hex-float converter, bound to the top level.
// Depends on ihfd_pkg and the ibm_hex_float_to_ieee_double_top ports.
module ihfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] double_bits,
  input logic [1:0]  status
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(double_bits))
    else $error("result changed under stall");

  // status code never out of range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status code");

  // bad length always gives zero bits
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ihfd_pkg::STATUS_BADLEN |-> double_bits == 64'd0)
    else $error("bad length with nonzero data");

  // missing value gives the NA pattern
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ihfd_pkg::STATUS_MISSING |-> double_bits == ihfd_pkg::NA_PATTERN)
    else $error("missing value pattern wrong");

  // an accepted input reaches out_valid through the input and result registers when output is free
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result lost");

endmodule

bind ibm_hex_float_to_ieee_double_top ihfd_checker u_ihfd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .double_bits(double_bits),
  .status     (status)
);
